[hw/rtl/fa_pkg.sv]
`timescale 1ns / 1ps

package fa_pkg;

  // default operand width
  localparam int unsigned FA_WIDTH = 32;

  // port widths fixed by the interface
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned STAT_W = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF      = 2'd2;

endpackage

[hw/rtl/fa_mul.sv]
`timescale 1ns / 1ps

module fa_mul import fa_pkg::*; #(
  parameter int unsigned WIDTH = FA_WIDTH
) (
  input  logic                 clk_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic [2*WIDTH-1:0]   p_o
);

  logic [2*WIDTH-1:0] p_d;
  logic [2*WIDTH-1:0] p_q;

  // full-width unsigned product, registered
  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

[hw/rtl/fa_gcd.sv]
`timescale 1ns / 1ps

module fa_gcd import fa_pkg::*; #(
  parameter int unsigned WIDTH = FA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*WIDTH-1:0]   a_i,
  input  logic [2*WIDTH-1:0]   b_i,
  output logic                 done_o,
  output logic [2*WIDTH-1:0]   g_o
);

  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned SW = $clog2(PW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [PW-1:0] a_q, a_d;
  logic [PW-1:0] b_q, b_d;
  logic [SW-1:0] sh_q, sh_d;

  // one binary gcd step per cycle: strip twos, subtract, then restore common twos
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      a_d    = a_i;
      b_d    = b_i;
      sh_d   = '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        if (sh_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          a_d  = a_q << 1;
          sh_d = sh_q - 1'b1;
        end
      end else if (a_q == '0) begin
        a_d = b_q;
        b_d = '0;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d  = a_q >> 1;
        b_d  = b_q >> 1;
        sh_d = sh_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = b_q;
        b_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    sh_q <= sh_d;
  end

  assign done_o = done_q;
  assign g_o    = a_q;

endmodule

[hw/rtl/fa_div.sv]
`timescale 1ns / 1ps

module fa_div import fa_pkg::*; #(
  parameter int unsigned WIDTH = FA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*WIDTH-1:0]   dividend_i,
  input  logic [2*WIDTH-1:0]   divisor_i,
  output logic                 done_o,
  output logic [2*WIDTH-1:0]   quo_o,
  output logic [2*WIDTH-1:0]   rem_o
);

  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned CW = $clog2(PW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] dvs_q, dvs_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [PW:0]   trial;
  logic [PW:0]   diff;
  logic          fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, quo_q[PW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(PW - 1);
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[PW-1:0] : trial[PW-1:0];
      quo_d = {quo_q[PW-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/fraction_accumulator_alu.sv]
`timescale 1ns / 1ps
// Fraction accumulator: holds one fraction in lowest terms with a positive
// denominator and applies one command per input word (load, add, subtract,
// multiply, divide) with the operand fraction.
// Input channel: in_valid_i / in_stall_o with cmd_i, operand_num_i and
// operand_den_i; a word is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with result_num_o, result_den_o
// and status_o; exactly one result word per input word, in order.
// One word is worked on at a time; in_stall_o is high from acceptance until
// the result is written to the output register. An error word (zero
// denominator, divide by zero, unknown command) goes straight to the output
// state. Otherwise a word takes three products on the shared multiplier,
// the binary GCD loop at one shift or subtract per cycle, and two quotients
// of 2*WIDTH bits each on the restoring divider.
// Reset sets the accumulator to 0/1 and empties the output register.
// A result held by out_stall_i does not block the next input word; the
// block only waits at its end if the output register is still full.

module fraction_accumulator_alu import fa_pkg::*; #(
  parameter int unsigned WIDTH = FA_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [NUM_W-1:0]  operand_num_i,
  input  logic signed [NUM_W-1:0]  operand_den_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [NUM_W-1:0]  result_num_o,
  output logic [DEN_W-1:0]         result_den_o,
  output logic [STAT_W-1:0]        status_o
);

  localparam int unsigned W  = WIDTH;
  localparam int unsigned PW = 2 * WIDTH;
  localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic [CMD_W-1:0]  cmd_q;
  logic              c_neg_q;
  logic [W-1:0]      c_mag_q;
  logic [W-1:0]      d_mag_q;
  logic [PW-1:0]     prod_q [3];
  logic [PW-1:0]     n_q;
  logic              n_neg_q;
  logic [PW-1:0]     den_q;
  logic [PW-1:0]     g_q;
  logic [STAT_W-1:0] status_q;

  logic signed [W-1:0] acc_num_q;
  logic [W-2:0]        acc_den_q;

  logic                    out_valid_q;
  logic signed [NUM_W-1:0] result_num_q;
  logic [DEN_W-1:0]        result_den_q;
  logic [STAT_W-1:0]       result_stat_q;

  logic          accept;
  logic          out_free;
  logic [W-1:0]  opn, opd;
  logic          on_neg, od_neg;
  logic [W-1:0]  on_mag, od_mag;
  logic          in_c_neg;
  logic          in_bad_cmd;
  logic          in_zero_den;

  logic          acc_neg;
  logic [W-1:0]  acc_mag;
  logic [W-1:0]  acc_den_w;

  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] mul_p;

  logic          s0, s1;
  logic          sum_neg;
  logic [PW-1:0] sum_mag;

  logic          gcd_start, gcd_done;
  logic [PW-1:0] gcd_g;
  logic          div_start, div_done;
  logic [PW-1:0] div_dvd, div_dvs, div_quo, div_rem;

  logic          ovf;
  logic signed [W-1:0] n_signed;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // operand decode: low WIDTH bits, sign moved onto the numerator
  always_comb begin
    opn         = operand_num_i[W-1:0];
    opd         = operand_den_i[W-1:0];
    on_neg      = opn[W-1];
    od_neg      = opd[W-1];
    on_mag      = on_neg ? W'(~opn + 1'b1) : opn;
    od_mag      = od_neg ? W'(~opd + 1'b1) : opd;
    in_c_neg    = (on_neg ^ od_neg) && (on_mag != '0);
    in_bad_cmd  = cmd_i > CMD_DIV;
    in_zero_den = (od_mag == '0) || ((cmd_i == CMD_DIV) && (on_mag == '0));
  end

  // accumulator as sign and magnitude
  assign acc_neg   = acc_num_q[W-1];
  assign acc_mag   = acc_neg ? W'(~acc_num_q + 1'b1) : acc_num_q;
  assign acc_den_w = W'(acc_den_q);

  // multiplier operand schedule: step 0 and 1 build the numerator, step 2 the denominator
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_q)
      CMD_LOAD: begin
        if (step_q == 2'd0) begin
          mul_a = c_mag_q;
          mul_b = W'(1);
        end else if (step_q == 2'd2) begin
          mul_a = d_mag_q;
          mul_b = W'(1);
        end
      end
      CMD_ADD, CMD_SUB: begin
        if (step_q == 2'd0) begin
          mul_a = acc_mag;
          mul_b = d_mag_q;
        end else if (step_q == 2'd1) begin
          mul_a = c_mag_q;
          mul_b = acc_den_w;
        end else begin
          mul_a = acc_den_w;
          mul_b = d_mag_q;
        end
      end
      CMD_MUL: begin
        if (step_q == 2'd0) begin
          mul_a = acc_mag;
          mul_b = c_mag_q;
        end else if (step_q == 2'd2) begin
          mul_a = acc_den_w;
          mul_b = d_mag_q;
        end
      end
      CMD_DIV: begin
        if (step_q == 2'd0) begin
          mul_a = acc_mag;
          mul_b = d_mag_q;
        end else if (step_q == 2'd2) begin
          mul_a = acc_den_w;
          mul_b = c_mag_q;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fa_mul #(.WIDTH(WIDTH)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // signed sum of the two numerator terms
  always_comb begin
    case (cmd_q)
      CMD_LOAD:         s0 = c_neg_q;
      CMD_ADD, CMD_SUB: s0 = acc_neg;
      default:          s0 = acc_neg ^ c_neg_q;
    endcase
    s0 = s0 && (prod_q[0] != '0);
    s1 = (c_neg_q ^ (cmd_q == CMD_SUB)) && (prod_q[1] != '0);
    if (s0 == s1) begin
      sum_neg = s0;
      sum_mag = prod_q[0] + prod_q[1];
    end else if (prod_q[0] >= prod_q[1]) begin
      sum_neg = s0;
      sum_mag = prod_q[0] - prod_q[1];
    end else begin
      sum_neg = s1;
      sum_mag = prod_q[1] - prod_q[0];
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  assign gcd_start = state_q == S_SUM;

  fa_gcd #(.WIDTH(WIDTH)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (sum_mag),
    .b_i     (prod_q[2]),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  // one divider serves the numerator, then the denominator
  assign div_start = ((state_q == S_GCD) && gcd_done) || ((state_q == S_DIVN) && div_done);
  assign div_dvd   = (state_q == S_DIVN) ? den_q : n_q;
  assign div_dvs   = (state_q == S_GCD) ? gcd_g : g_q;

  fa_div #(.WIDTH(WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // range check of the reduced fraction
  assign ovf      = (den_q >= LIM) || (n_neg_q ? (n_q > LIM) : (n_q >= LIM));
  assign n_signed = n_neg_q ? W'(~n_q[W-1:0] + 1'b1) : n_q[W-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (accept) begin
          state_d = (in_bad_cmd || in_zero_den) ? S_OUT : S_MUL;
        end
      end
      S_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) begin
          state_d = S_SUM;
        end
      end
      S_SUM:  state_d = S_GCD;
      S_GCD:  if (gcd_done) state_d = S_DIVN;
      S_DIVN: if (div_done) state_d = S_DIVD;
      S_DIVD: if (div_done) state_d = S_CHK;
      S_CHK:  state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // accumulator and word status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_num_q <= '0;
      acc_den_q <= (W-1)'(1);
      status_q  <= ST_OK;
    end else if (accept) begin
      status_q <= in_zero_den && !in_bad_cmd ? ST_ZERO_DEN : ST_OK;
    end else if (state_q == S_CHK) begin
      if (n_q == '0) begin
        acc_num_q <= '0;
        acc_den_q <= (W-1)'(1);
        status_q  <= ST_OK;
      end else if (ovf) begin
        status_q <= ST_OVF;
      end else begin
        acc_num_q <= n_signed;
        acc_den_q <= den_q[W-2:0];
        status_q  <= ST_OK;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      c_neg_q <= in_c_neg;
      c_mag_q <= on_mag;
      d_mag_q <= od_mag;
    end
    if (state_q == S_MUL) begin
      case (step_q)
        2'd1:    prod_q[0] <= mul_p;
        2'd2:    prod_q[1] <= mul_p;
        2'd3:    prod_q[2] <= mul_p;
        default: prod_q[0] <= prod_q[0];
      endcase
    end
    if (state_q == S_SUM) begin
      n_q     <= sum_mag;
      n_neg_q <= sum_neg;
      den_q   <= prod_q[2];
    end
    if ((state_q == S_GCD) && gcd_done) begin
      g_q <= gcd_g;
    end
    if ((state_q == S_DIVN) && div_done) begin
      n_q <= div_quo;
    end
    if ((state_q == S_DIVD) && div_done) begin
      den_q <= div_quo;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      result_num_q  <= NUM_W'(acc_num_q);
      result_den_q  <= DEN_W'(acc_den_q);
      result_stat_q <= status_q;
    end
  end

  assign in_stall_o   = state_q != S_IDLE;
  assign out_valid_o  = out_valid_q;
  assign result_num_o = result_num_q;
  assign result_den_o = result_den_q;
  assign status_o     = result_stat_q;

  // checks
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_den_o != '0)
    else $error("result denominator is zero");

  a_zero_is_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_num_o == '0) |-> result_den_o == DEN_W'(1))
    else $error("zero result not reported as 0/1");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> gcd_g != '0)
    else $error("gcd unit returned zero");

  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> div_rem == '0)
    else $error("reduction left a remainder");

endmodule

[sim/tb_fraction_accumulator_alu.sv]
`timescale 1ns / 1ps

module tb_fraction_accumulator_alu;
  import fa_pkg::*;

  localparam int unsigned W            = FA_WIDTH;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned N_WORDS      = 1350;
  localparam int unsigned QUIET_WORDS  = 150;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = 700;
  localparam int unsigned WATCHDOG_MAX = 8000;

  // one expected result word
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [STAT_W-1:0] status;
  } frac_result_t;

  // running fraction model and queue of expected result words
  class frac_scoreboard;
    logic [31:0]  acc_num;
    logic [31:0]  acc_den;
    frac_result_t expected_q[$];
    int           errors;

    function new();
      acc_num = '0;
      acc_den = 32'd1;
      errors  = 0;
    endfunction

    // apply one accepted input word to the model and queue its result
    function void note_word(logic [CMD_W-1:0] cmd, logic [NUM_W-1:0] onum,
                             logic [NUM_W-1:0] oden);
      logic [63:0]       mask, lim, v, c_mag, d_mag, a_mag, ad, p_mag, q_mag;
      logic [63:0]       n_mag, den, x, y, t;
      logic              c_neg, d_neg, a_neg, p_neg, q_neg, n_neg;
      logic [STAT_W-1:0] st;
      frac_result_t      r;
      mask  = (64'd1 << W) - 64'd1;
      lim   = 64'd1 << (W - 1);
      v     = {32'd0, onum} & mask;
      c_neg = v[W-1];
      c_mag = c_neg ? ((~v + 64'd1) & mask) : v;
      v     = {32'd0, oden} & mask;
      d_neg = v[W-1];
      d_mag = d_neg ? ((~v + 64'd1) & mask) : v;
      a_neg = acc_num[31];
      a_mag = a_neg ? {32'd0, ~acc_num + 32'd1} : {32'd0, acc_num};
      ad    = {32'd0, acc_den};
      n_neg = 1'b0;
      n_mag = '0;
      den   = 64'd1;
      // operand sign lives on the numerator
      if (d_neg) c_neg = ~c_neg;
      if (c_mag == 0) c_neg = 1'b0;
      st = ST_OK;
      if (cmd <= CMD_DIV) begin
        if (d_mag == 0 || (cmd == CMD_DIV && c_mag == 0)) begin
          st = ST_ZERO_DEN;
        end else begin
          case (cmd)
            CMD_LOAD: begin
              n_neg = c_neg;
              n_mag = c_mag;
              den   = d_mag;
            end
            CMD_ADD, CMD_SUB: begin
              p_neg = a_neg;
              p_mag = a_mag * d_mag;
              q_neg = (cmd == CMD_SUB) ? ~c_neg : c_neg;
              q_mag = c_mag * ad;
              if (p_mag == 0) p_neg = 1'b0;
              if (q_mag == 0) q_neg = 1'b0;
              if (p_neg == q_neg) begin
                n_neg = p_neg;
                n_mag = p_mag + q_mag;
              end else if (p_mag >= q_mag) begin
                n_neg = p_neg;
                n_mag = p_mag - q_mag;
              end else begin
                n_neg = q_neg;
                n_mag = q_mag - p_mag;
              end
              den = ad * d_mag;
            end
            CMD_MUL: begin
              n_neg = a_neg ^ c_neg;
              n_mag = a_mag * c_mag;
              den   = ad * d_mag;
            end
            CMD_DIV: begin
              n_neg = a_neg ^ c_neg;
              n_mag = a_mag * d_mag;
              den   = ad * c_mag;
            end
            default: ;
          endcase
          // reduce to lowest terms
          x = n_mag;
          y = den;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          if (x != 0) begin
            n_mag = n_mag / x;
            den   = den / x;
          end
          if (n_mag == 0) begin
            n_neg = 1'b0;
            den   = 64'd1;
          end
          // write back only when it fits
          if (den > lim - 64'd1 || n_mag > (n_neg ? lim : lim - 64'd1)) begin
            st = ST_OVF;
          end else begin
            acc_num = n_neg ? (~n_mag[31:0] + 32'd1) : n_mag[31:0];
            acc_den = den[31:0];
          end
        end
      end
      r.num    = acc_num;
      r.den    = acc_den[DEN_W-1:0];
      r.status = st;
      expected_q.push_back(r);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den,
                             logic [STAT_W-1:0] st);
      frac_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word num=%0d den=%0d status=%0d",
                 $time, $signed(num), den, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (num !== e.num) begin
        $display("%0t: result_num expected %0d actual %0d",
                 $time, $signed(e.num), $signed(num));
        errors++;
      end
      if (den !== e.den) begin
        $display("%0t: result_den expected %0d actual %0d", $time, e.den, den);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        cmd_i;
  logic signed [NUM_W-1:0] operand_num_i;
  logic signed [NUM_W-1:0] operand_den_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [NUM_W-1:0] result_num_o;
  logic [DEN_W-1:0]        result_den_o;
  logic [STAT_W-1:0]       status_o;

  frac_scoreboard sb = new();
  int unsigned    n_accepted = 0;
  int unsigned    idle_cycles = 0;
  logic           quiet = 1'b0;
  logic           hold_done = 1'b0;

  fraction_accumulator_alu #(
    .WIDTH(W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .operand_num_i(operand_num_i),
    .operand_den_i(operand_den_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_num_o (result_num_o),
    .result_den_o (result_den_o),
    .status_o     (status_o)
  );

  // clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // operand mix: mostly small values, some extremes and wide values
  function automatic logic [NUM_W-1:0] rand_operand();
    logic [NUM_W-1:0] v;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4, 5, 6: v = 32'($urandom_range(0, 24)) - 32'd12;
      7: v = $urandom();
      8: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      9: begin
        v = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
      end
      10: v = 32'($urandom_range(0, 65535)) - 32'd32768;
      default: v = 32'd1;
    endcase
    return v;
  endfunction

  // offer one word, with an occasional idle burst ahead of it
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NUM_W-1:0] num,
                           input logic [NUM_W-1:0] den);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    operand_num_i <= num;
    operand_den_i <= den;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(cmd, num, den);
    n_accepted++;
  endtask

  // result side: random stall bursts and one long hold-off
  initial begin : result_stall
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && n_accepted >= HOLD_AT) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(result_num_o, result_den_o, status_o);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [CMD_W-1:0] cmd;
    int unsigned      seq_left;
    int unsigned      r;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_LOAD;
    operand_num_i <= '0;
    operand_den_i <= 32'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words
    send_word(CMD_ADD,  32'd1,         32'd2);         // from the reset value
    send_word(CMD_LOAD, 32'd6,         -32'sd4);       // sign moves, reduces
    send_word(CMD_LOAD, 32'd7,         32'd0);         // zero denominator
    send_word(CMD_DIV,  32'd0,         32'd5);         // divide by zero
    send_word(CMD_LOAD, 32'd0,         -32'sd7);       // zero stored as 0/1
    send_word(CMD_LOAD, 32'h8000_0000, 32'd1);         // most negative
    send_word(CMD_LOAD, 32'h7fff_ffff, 32'd1);         // most positive
    send_word(CMD_LOAD, 32'd1,         32'h8000_0000); // denominator too wide
    send_word(CMD_LOAD, 32'h8000_0000, 32'hffff_ffff); // sign flip too wide
    send_word(CMD_LOAD, 32'h8000_0000, 32'd2);
    send_word(CMD_MUL,  32'd4,         32'd1);         // numerator too wide
    send_word(CMD_SUB,  32'h4000_0000, 32'd1);         // lands on the minimum
    send_word(CMD_ADD,  32'h7fff_ffff, 32'd1);
    send_word(CMD_LOAD, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(CMD_LOAD, 32'd3,         32'd7);
    send_word(CMD_SUB,  32'd3,         32'd7);         // zero result
    send_word(CMD_LOAD, 32'd5,         32'd3);
    send_word(CMD_MUL,  -32'sd3,       32'd5);
    send_word(CMD_DIV,  32'd2,         -32'sd7);
    send_word(CMD_ADD,  32'd1,         32'h7fff_ffff); // denominator overflow
    for (int c = int'(CMD_DIV) + 1; c < (1 << CMD_W); c++) begin
      send_word(CMD_W'(c), $urandom(), $urandom());    // unknown commands
    end
    send_word(CMD_LOAD, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_DIV,  32'h8000_0000, 32'd1);
    send_word(CMD_DIV,  32'h7fff_ffff, 32'h8000_0000);

    // random sequences: a load followed by a run of arithmetic
    seq_left = 0;
    while (n_accepted < N_WORDS) begin
      if (n_accepted >= N_WORDS - QUIET_WORDS) quiet = 1'b1;
      if (seq_left == 0) begin
        cmd      = CMD_LOAD;
        seq_left = $urandom_range(3, 12);
      end else begin
        seq_left--;
        r = $urandom_range(0, 99);
        if (r < 4) cmd = CMD_W'($urandom_range(int'(CMD_DIV) + 1, (1 << CMD_W) - 1));
        else if (r < 8) cmd = CMD_LOAD;
        else cmd = CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_DIV)));
      end
      send_word(cmd, rand_operand(), rand_operand());
    end
    in_valid_i <= 1'b0;

    // drain
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
